// ----- sv/scgm_pkg.sv -----
// shared types, constants and register indexes of the stereo crossfade gain meter
`default_nettype none
package scgm_pkg;

	localparam int unsigned DEF_MAX_BLOCK   = 4096;
	localparam int unsigned DEF_SAMPLE_BITS = 16;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PREVIOUS_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MUTE          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING     = 3'd5;

	localparam logic [16:0] ONE_Q16       = 17'd65536;
	localparam logic signed [15:0] LEVEL_FLOOR = -16'sd25600;
	localparam int QUIET_DB          = -20480;
	localparam int DB_PER_OCTAVE_Q16 = 197283;
	localparam int SUM_W             = 44;

	typedef struct packed {
		logic [16:0] fade_step;
		logic [15:0] active_gain;
		logic [15:0] previous_gain;
		logic [15:0] master_gain;
		logic        mute;
		logic [15:0] smoothing;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] new_left;
		logic signed [15:0] new_right;
		logic signed [15:0] old_left;
		logic signed [15:0] old_right;
		logic               old_valid;
		logic               begin_fade;
		logic               block_end;
	} item_t;

endpackage
`default_nettype wire

// ----- sv/scgm_front.sv -----
// front end: accepts frames into a two-entry queue towards the engine
`default_nettype none
module scgm_front
	import scgm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire item_t       in_item,
	output logic             q_valid,
	output item_t            q_item,
	input  wire logic        q_pop
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop && q_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop && q_valid})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/scgm_back.sv -----
// back end: sequenced mix, gain, metering and log level engine on one shared multiplier
`default_nettype none
module scgm_back
	import scgm_pkg::*;
#(
	parameter int unsigned MAX_BLOCK = DEF_MAX_BLOCK
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cfg_t         cfg,
	input  wire logic         q_valid,
	input  wire item_t        q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [15:0]       out_left,
	output logic [15:0]       out_right,
	output logic [15:0]       out_level,
	output logic              out_level_valid
);

	localparam int unsigned MW = 34;
	localparam int unsigned PW = 2 * MW;
	localparam int unsigned CW = $clog2(MAX_BLOCK + 1);
	localparam int unsigned LW = 24;

	localparam logic signed [PW-1:0] H13 = PW'(4096);
	localparam logic signed [PW-1:0] H16 = PW'(32768);
	localparam logic signed [PW-1:0] H24 = PW'(8388608);
	localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (DEF_SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);
	localparam logic signed [PW-1:0] QUIET  = PW'(QUIET_DB);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCK);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FRAME = 6'b000010,
		ST_NORM  = 6'b000100,
		ST_LOG   = 6'b001000,
		ST_DB    = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t state_q;
	logic [3:0] step_q;
	item_t item_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod_q, acc_q;
	logic signed [MW-1:0] a0_q, a1_q, b0_q, b1_q, y0_q, y1_q;
	logic [16:0] fp_q, g_q;
	logic        fading_q;
	logic [SUM_W-1:0] sum_q;
	logic [CW-1:0] cnt_q, blk_cnt_q;
	logic signed [15:0] level_q;
	logic        lv_q;

	logic [SUM_W-1:0] norm_q;
	logic [5:0]  sh_q;
	logic [31:0] m_q;
	logic [15:0] frac_q;
	logic [3:0]  iter_q;
	logic        phase_q;
	logic        pass_q;
	logic [21:0] lg1_q;
	logic [1:0]  dstep_q;
	logic signed [16:0] db_q;

	logic [16:0] fp_eff;
	logic        fading;
	logic [17:0] fp_sum;
	logic signed [PW-1:0] r13, r16m, r24, r16s;
	logic signed [PW-1:0] ysat;
	logic [SUM_W-1:0] sum_next;
	logic [CW-1:0] cnt_next;
	logic        blk_done;
	logic [32:0] sq;
	logic [21:0] lg;
	logic signed [LW-1:0] l_val;
	logic signed [17:0] diff;
	logic [17:0] inv_g;

	always_comb begin
		fp_eff = item_q.begin_fade ? 17'd0 : fp_q;
		if ((fp_eff < ONE_Q16) && !item_q.old_valid) begin
			fp_eff = ONE_Q16;
		end
		fading = (fp_eff < ONE_Q16);
		fp_sum = {1'b0, fp_eff} + {1'b0, cfg.fade_step};
	end

	assign inv_g    = 18'({1'b0, ONE_Q16}) - 18'({1'b0, g_q});
	assign r13      = (prod_q + H13) >>> 13;
	assign r16m     = (acc_q + prod_q + H16) >>> 16;
	assign r24      = (prod_q + H24) >>> 24;
	assign r16s     = (prod_q + H16) >>> 16;
	assign ysat     = (r13 > SAT_HI) ? SAT_HI : ((r13 < SAT_LO) ? SAT_LO : r13);
	assign sum_next = sum_q + prod_q[SUM_W-1:0];
	assign cnt_next = cnt_q + CW'(1);
	assign blk_done = item_q.block_end || (cnt_next >= MAX_CNT);
	assign sq       = prod_q[63:31];
	assign lg       = {6'd43 - sh_q, frac_q};
	assign l_val    = LW'(lg1_q) - LW'(lg) - LW'(30 * 65536);
	assign diff     = 18'(db_q) - 18'(level_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_FRAME: begin
				case (step_q)
					4'd0: begin mul_a = MW'(item_q.new_left);  mul_b = MW'(cfg.active_gain); end
					4'd1: begin mul_a = MW'(item_q.new_right); mul_b = MW'(cfg.active_gain); end
					4'd2: begin mul_a = MW'(item_q.old_left);  mul_b = MW'(cfg.previous_gain); end
					4'd3: begin mul_a = MW'(item_q.old_right); mul_b = MW'(cfg.previous_gain); end
					4'd4: begin mul_a = a0_q; mul_b = MW'(g_q); end
					4'd5: begin mul_a = b0_q; mul_b = MW'(inv_g); end
					4'd6: begin mul_a = a1_q; mul_b = MW'(g_q); end
					4'd7: begin mul_a = b1_q; mul_b = MW'(inv_g); end
					4'd8: begin mul_a = y0_q; mul_b = MW'(cfg.master_gain); end
					4'd9: begin mul_a = y1_q; mul_b = MW'(cfg.master_gain); end
					4'd10: begin mul_a = y0_q; mul_b = y0_q; end
					4'd11: begin mul_a = y1_q; mul_b = y1_q; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_LOG: begin
				mul_a = MW'(m_q);
				mul_b = MW'(m_q);
			end
			ST_DB: begin
				if (dstep_q == 2'd0) begin
					mul_a = MW'(l_val);
					mul_b = MW'(DB_PER_OCTAVE_Q16);
				end else begin
					mul_a = MW'(diff);
					mul_b = MW'(cfg.smoothing);
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(mul_b);
		if (q_pop) begin
			item_q <= q_item;
		end
		if (state_q == ST_FRAME) begin
			case (step_q)
				4'd0: begin
					g_q      <= fp_eff;
					fading_q <= fading;
				end
				4'd1: a0_q <= MW'(r13);
				4'd2: a1_q <= MW'(r13);
				4'd3: b0_q <= MW'(r13);
				4'd4: b1_q <= MW'(r13);
				4'd5: acc_q <= prod_q;
				4'd6: y0_q <= fading_q ? MW'(r16m) : a0_q;
				4'd7: acc_q <= prod_q;
				4'd8: y1_q <= fading_q ? MW'(r16m) : a1_q;
				4'd9: y0_q <= cfg.mute ? '0 : MW'(ysat);
				4'd10: y1_q <= cfg.mute ? '0 : MW'(ysat);
				4'd12: begin
					blk_cnt_q <= cnt_next;
					norm_q    <= sum_next;
					sh_q      <= 6'd0;
					pass_q    <= 1'b0;
					db_q      <= 17'(LEVEL_FLOOR);
				end
				default: ;
			endcase
		end
		if (state_q == ST_NORM) begin
			if (!norm_q[SUM_W-1]) begin
				norm_q <= norm_q << 1;
				sh_q   <= sh_q + 6'd1;
			end else begin
				m_q     <= norm_q[SUM_W-1:SUM_W-32];
				frac_q  <= 16'd0;
				iter_q  <= 4'd0;
				phase_q <= 1'b0;
			end
		end
		if (state_q == ST_LOG) begin
			phase_q <= ~phase_q;
			if (phase_q) begin
				iter_q <= iter_q + 4'd1;
				m_q    <= sq[32] ? sq[32:1] : sq[31:0];
				frac_q <= {frac_q[14:0], sq[32]};
				if (iter_q == 4'd15 && !pass_q) begin
					pass_q <= 1'b1;
				end
			end
		end
		if (state_q == ST_LOG && phase_q && iter_q == 4'd15 && !pass_q) begin
			lg1_q  <= {6'd43 - sh_q, frac_q[14:0], sq[32]};
			norm_q <= SUM_W'(blk_cnt_q) << 1;
			sh_q   <= 6'd0;
		end
		if (state_q == ST_DB && dstep_q == 2'd1) begin
			db_q <= (r24 <= QUIET) ? 17'(LEVEL_FLOOR) : 17'(r24);
		end
		if (state_q == ST_OUT && (!out_valid || out_ready)) begin
			out_left        <= y0_q[15:0];
			out_right       <= y1_q[15:0];
			out_level       <= level_q;
			out_level_valid <= lv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= 4'd0;
			dstep_q   <= 2'd0;
			fp_q      <= ONE_Q16;
			sum_q     <= '0;
			cnt_q     <= '0;
			level_q   <= LEVEL_FLOOR;
			lv_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_FRAME;
						step_q  <= 4'd0;
					end
				end
				ST_FRAME: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						4'd0: fp_q <= fading ? ((fp_sum > 18'(ONE_Q16)) ? ONE_Q16 :
							fp_sum[16:0]) : fp_eff;
						4'd11: sum_q <= sum_next;
						4'd12: begin
							if (blk_done) begin
								sum_q <= '0;
								cnt_q <= '0;
								lv_q  <= 1'b1;
								if (sum_next == '0) begin
									state_q <= ST_DB;
									dstep_q <= 2'd2;
								end else begin
									state_q <= ST_NORM;
								end
							end else begin
								sum_q   <= sum_next;
								cnt_q   <= cnt_next;
								lv_q    <= 1'b0;
								state_q <= ST_OUT;
							end
						end
						default: ;
					endcase
				end
				ST_NORM: begin
					if (norm_q[SUM_W-1]) begin
						state_q <= ST_LOG;
					end
				end
				ST_LOG: begin
					if (phase_q && iter_q == 4'd15) begin
						if (!pass_q) begin
							state_q <= ST_NORM;
						end else begin
							state_q <= ST_DB;
							dstep_q <= 2'd0;
						end
					end
				end
				ST_DB: begin
					dstep_q <= dstep_q + 2'd1;
					if (dstep_q == 2'd3) begin
						level_q <= level_q + 16'(r16s);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- sv/stereo_crossfade_gain_meter_core.sv -----
// top level: configuration registers, frame queue and level engine of the crossfade meter
// a frame passes from queue to output register one transaction at a time
// a block-ending frame adds two log passes, each a normalise step and a squaring loop,
// then the dB and smoothing steps; a block whose sum is zero skips the log passes
// mix, gain, meter, log and dB steps share one multiplier; a two-entry queue takes input
// reset clears queue, fade (no fade running), block sum and count, level to -100 dB
`default_nettype none
module stereo_crossfade_gain_meter_core
	import scgm_pkg::*;
#(
	parameter int unsigned MAX_BLOCK = DEF_MAX_BLOCK
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [63:0]           s_tdata,  // new_left, new_right, old_left, old_right
	input  wire logic [1:0]            s_tuser,  // old_valid, begin_fade
	input  wire logic                  s_tlast,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [47:0]                m_tdata,  // out_left, out_right, level_db
	output logic [0:0]                 m_tuser,  // level_valid
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t  cfg_q;
	item_t in_item, q_item;
	logic  q_valid, q_pop;
	logic [15:0] o_left, o_right, o_level;
	logic  o_lv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fade_step     <= 17'd1365;
			cfg_q.active_gain   <= 16'd8192;
			cfg_q.previous_gain <= 16'd8192;
			cfg_q.master_gain   <= 16'd8192;
			cfg_q.mute          <= 1'b0;
			cfg_q.smoothing     <= 16'd19661;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FADE_STEP:     cfg_q.fade_step     <= cfg_wdata;
				REG_ACTIVE_GAIN:   cfg_q.active_gain   <= cfg_wdata[15:0];
				REG_PREVIOUS_GAIN: cfg_q.previous_gain <= cfg_wdata[15:0];
				REG_MASTER_GAIN:   cfg_q.master_gain   <= cfg_wdata[15:0];
				REG_MUTE:          cfg_q.mute          <= cfg_wdata[0];
				REG_SMOOTHING:     cfg_q.smoothing     <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		in_item.new_left   = s_tdata[15:0];
		in_item.new_right  = s_tdata[31:16];
		in_item.old_left   = s_tdata[47:32];
		in_item.old_right  = s_tdata[63:48];
		in_item.old_valid  = s_tuser[0];
		in_item.begin_fade = s_tuser[1];
		in_item.block_end  = s_tlast;
	end

	scgm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	scgm_back #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_left        (o_left),
		.out_right       (o_right),
		.out_level       (o_level),
		.out_level_valid (o_lv)
	);

	assign m_tdata = {o_level, o_right, o_left};
	assign m_tuser = o_lv;

endmodule
`default_nettype wire

// ----- tb/stereo_crossfade_gain_meter_core_checker.sv -----
// checker for the crossfade meter: watches both streams, predicts each frame and compares
module stereo_crossfade_gain_meter_core_checker
	import scgm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [63:0]           s_tdata,
	input  wire logic [1:0]            s_tuser,
	input  wire logic                  s_tlast,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [47:0]           m_tdata,
	input  wire logic [0:0]            m_tuser,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                         errors,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [15:0] out_left;
		logic signed [15:0] out_right;
		logic signed [15:0] level_db;
		logic               level_valid;
	} frame_out_t;

	cfg_t            regs;
	logic [16:0]     progress;
	logic [43:0]     sq_sum;
	logic [12:0]     n_frames;
	logic signed [15:0] level;
	frame_out_t      expected_frames[$];

	function automatic longint rnd_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint log2_fix(longint unsigned x);
		int p;
		longint unsigned m;
		longint frac;
		p = 0;
		frac = 0;
		while (p < 63 && (x >> (p + 1)) != 0)
			p++;
		if (p >= 31)
			m = x >> (p - 31);
		else
			m = x << (31 - p);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= (64'd1 << 32)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return (longint'(p) << 16) + frac;
	endfunction

	function automatic longint block_level(longint unsigned sum, int cnt);
		longint l, db;
		if (sum == 0 || cnt == 0)
			return LEVEL_FLOOR;
		l = log2_fix(sum) - log2_fix(longint'(cnt) * 2) - (longint'(30) << 16);
		db = rnd_shift(l * DB_PER_OCTAVE_Q16, 24);
		if (db <= QUIET_DB)
			return LEVEL_FLOOR;
		return db;
	endfunction

	function automatic longint clip_sample(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	task automatic mix_frame(input item_t it);
		longint a[2], b[2], y[2];
		longint g, db;
		int cnt;
		frame_out_t r;
		a[0] = rnd_shift(longint'(it.new_left) * regs.active_gain, 13);
		a[1] = rnd_shift(longint'(it.new_right) * regs.active_gain, 13);
		b[0] = rnd_shift(longint'(it.old_left) * regs.previous_gain, 13);
		b[1] = rnd_shift(longint'(it.old_right) * regs.previous_gain, 13);
		if (it.begin_fade)
			progress = 0;
		if (progress < ONE_Q16 && !it.old_valid)
			progress = ONE_Q16;
		if (progress < ONE_Q16) begin
			g = progress;
			for (int c = 0; c < 2; c++)
				y[c] = rnd_shift(a[c] * g + b[c] * (65536 - g), 16);
			g = g + regs.fade_step;
			progress = g > 65536 ? ONE_Q16 : g[16:0];
		end else begin
			y[0] = a[0];
			y[1] = a[1];
		end
		for (int c = 0; c < 2; c++) begin
			y[c] = regs.mute ? 0 : clip_sample(rnd_shift(y[c] * regs.master_gain, 13));
			sq_sum = sq_sum + 44'(y[c] * y[c]);
		end
		n_frames = n_frames + 1;
		cnt = n_frames;
		r.level_valid = 1'b0;
		if (it.block_end || cnt >= DEF_MAX_BLOCK) begin
			db = block_level(sq_sum, cnt);
			level = 16'(longint'(level) +
				rnd_shift((db - longint'(level)) * longint'(regs.smoothing), 16));
			sq_sum = 0;
			n_frames = 0;
			r.level_valid = 1'b1;
		end
		r.out_left = 16'(y[0]);
		r.out_right = 16'(y[1]);
		r.level_db = level;
		expected_frames.insert(expected_frames.size(), r);
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t it;
		frame_out_t want, got;
		if (!arst_n) begin
			regs <= '{fade_step: 17'd1365, active_gain: 16'd8192, previous_gain: 16'd8192,
				master_gain: 16'd8192, mute: 1'b0, smoothing: 16'd19661};
			progress = ONE_Q16;
			sq_sum = 0;
			n_frames = 0;
			level = LEVEL_FLOOR;
			expected_frames.delete();
			errors = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.out_left = m_tdata[15:0];
				got.out_right = m_tdata[31:16];
				got.level_db = m_tdata[47:32];
				got.level_valid = m_tuser[0];
				if (expected_frames.size() == 0) begin
					$display("unexpected output transaction at %0t", $time);
					errors++;
				end else begin
					want = expected_frames.pop_front();
					if (got.out_left != want.out_left)
						report("out_left", got.out_left, want.out_left);
					if (got.out_right != want.out_right)
						report("out_right", got.out_right, want.out_right);
					if (got.level_db != want.level_db)
						report("level_db", got.level_db, want.level_db);
					if (got.level_valid != want.level_valid)
						report("level_valid", got.level_valid, want.level_valid);
				end
			end
			if (s_tvalid && s_tready) begin
				it.new_left = s_tdata[15:0];
				it.new_right = s_tdata[31:16];
				it.old_left = s_tdata[47:32];
				it.old_right = s_tdata[63:48];
				it.old_valid = s_tuser[0];
				it.begin_fade = s_tuser[1];
				it.block_end = s_tlast;
				mix_frame(it);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_FADE_STEP: regs.fade_step <= cfg_wdata;
					REG_ACTIVE_GAIN: regs.active_gain <= cfg_wdata[15:0];
					REG_PREVIOUS_GAIN: regs.previous_gain <= cfg_wdata[15:0];
					REG_MASTER_GAIN: regs.master_gain <= cfg_wdata[15:0];
					REG_MUTE: regs.mute <= cfg_wdata[0];
					REG_SMOOTHING: regs.smoothing <= cfg_wdata[15:0];
					default: ;
				endcase
			end
		end
		pending = expected_frames.size();
	end
endmodule

// ----- tb/stereo_crossfade_gain_meter_core_test.sv -----
// top of the crossfade meter test: clock, reset, frame and register stimulus, verdict
module stereo_crossfade_gain_meter_core_test;
	import scgm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 4000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [63:0]           s_tdata = '0;  // new_left, new_right, old_left, old_right
	logic [1:0]            s_tuser = '0;  // old_valid, begin_fade
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [47:0]           m_tdata;       // out_left, out_right, level_db
	logic [0:0]            m_tuser;       // level_valid
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int                    errors;
	int                    pending;
	int                    idle_cycles = 0;
	int                    fade_left = 0;
	int                    block_len = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	stereo_crossfade_gain_meter_core u_top (.*);

	stereo_crossfade_gain_meter_core_checker u_checker (.*);

	always @(negedge clk) begin
		int r;
		r = $urandom_range(0, 15);
		if (r < 4)
			m_tready <= 1'b1;
		else if (r < 6)
			m_tready <= 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input logic [63:0] d, input logic [1:0] u, input logic last);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		s_tuser <= u;
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_random(input int count);
		logic [63:0] d;
		logic [1:0] u;
		logic last;
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 20);
				if ($urandom_range(0, 3) != 0) begin
					s_tvalid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(negedge clk);
				end
			end
			burst--;
			d = {$urandom, $urandom};
			if ($urandom_range(0, 3) == 0)
				d[15:0] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			if ($urandom_range(0, 7) == 0)
				d = d >>> $urandom_range(8, 15);
			u[1] = (fade_left == 0 && $urandom_range(0, 30) == 0);
			if (u[1])
				fade_left = $urandom_range(5, 60);
			u[0] = fade_left > 0 ? ($urandom_range(0, 40) != 0) : 1'($urandom_range(0, 1));
			if (fade_left > 0)
				fade_left--;
			block_len++;
			last = (block_len >= $urandom_range(1, 24));
			if (last)
				block_len = 0;
			send_frame(d, u, last);
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic drain;
		while (pending != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		// directed: extremes, fade start, old source ending, quiet and loud blocks
		send_frame({16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 2'b01, 1'b1);
		send_frame({16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 2'b11, 1'b0);
		send_frame({16'h1234, 16'hedcb, 16'h7fff, 16'h8000}, 2'b01, 1'b0);
		send_frame({16'h1234, 16'hedcb, 16'h7fff, 16'h8000}, 2'b00, 1'b1);
		send_frame('0, 2'b01, 1'b1);
		send_frame({48'h0, 16'h0001}, 2'b00, 1'b1);
		send_frame({16'hffff, 16'hffff, 16'hffff, 16'hffff}, 2'b11, 1'b1);
		s_tvalid <= 1'b0;
		drain();
		write_reg(REG_FADE_STEP, 17'd65536);
		write_reg(REG_ACTIVE_GAIN, 17'hffff);
		write_reg(REG_PREVIOUS_GAIN, 17'hffff);
		write_reg(REG_MASTER_GAIN, 17'hffff);
		write_reg(REG_SMOOTHING, 17'hffff);
		send_frame({16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 2'b11, 1'b0);
		send_frame({16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 2'b01, 1'b1);
		send_random(60);
		drain();
		write_reg(REG_FADE_STEP, 17'd0);
		write_reg(REG_ACTIVE_GAIN, 17'd0);
		write_reg(REG_MASTER_GAIN, 17'd1);
		write_reg(REG_SMOOTHING, 17'd0);
		send_frame({16'h4000, 16'h4000, 16'h8000, 16'h7fff}, 2'b11, 1'b0);
		send_frame({16'h4000, 16'h4000, 16'h8000, 16'h7fff}, 2'b01, 1'b1);
		send_random(60);
		drain();
		write_reg(REG_MUTE, 17'd1);
		write_reg(REG_SMOOTHING, 17'd32768);
		write_reg(REG_PREVIOUS_GAIN, 17'd0);
		send_random(40);
		drain();
		write_reg(REG_MUTE, 17'd0);
		write_reg(REG_FADE_STEP, 17'd1365);
		write_reg(REG_ACTIVE_GAIN, 17'd8192);
		write_reg(REG_PREVIOUS_GAIN, 17'd8192);
		write_reg(REG_MASTER_GAIN, 17'd8192);
		write_reg(REG_SMOOTHING, 17'd19661);
		send_random(320);
		drain();
		for (int k = 0; k < 3; k++) begin
			write_reg(REG_FADE_STEP, 17'($urandom_range(1, 4000)));
			write_reg(REG_ACTIVE_GAIN, 17'($urandom_range(0, 65535)));
			write_reg(REG_PREVIOUS_GAIN, 17'($urandom_range(0, 65535)));
			write_reg(REG_MASTER_GAIN, 17'($urandom_range(0, 20000)));
			write_reg(REG_SMOOTHING, 17'($urandom_range(0, 65535)));
			send_random(100);
			drain();
		end
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
